/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert that a property holds at every clock edge while out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tkf_pkg.sv */
// Package with types, constants and operation codes of the tilt Kalman filter.
`default_nettype none
package tkf_pkg;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int IN_WIDTH       = 25;
    localparam int CFG_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int DT_WIDTH       = 17;

    // Register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DT   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_Q    = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BIAS = 2'd3;

    // Commands.
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_RESTART,
        OP_LOAD,
        OP_FINISH
    } t_op;

    // Register file slots of the datapath.
    typedef enum logic [4:0] {
        R_ZERO, R_Y, R_U, R_DT, R_W, R_Q,
        R_PA, R_PB, R_P00, R_P01, R_P10, R_P11,
        R_S, R_G0, R_G1, R_D, R_TH, R_BI,
        R_C00, R_C01, R_C10, R_C11, R_A00, R_A01,
        R_T0, R_T1, R_DD
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg src_a;
        t_reg src_b;
        t_reg dst;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    localparam int PROG_LEN = 40;
    localparam int PC_WIDTH = 6;

    // Microprogram of one update step.
    function automatic t_cmd prog(input logic [PC_WIDTH-1:0] pc);
        t_cmd c;
        c = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO, 1'b0};
        case (pc)
            6'd0:  c = '{OP_LOAD, R_ZERO, R_ZERO, R_ZERO, 1'b1};
            6'd1:  c = '{OP_ADD, R_P00, R_W,   R_S,   1'b1};
            6'd2:  c = '{OP_DIV, R_P00, R_S,   R_G0,  1'b1};
            6'd3:  c = '{OP_DIV, R_P10, R_S,   R_G1,  1'b1};
            6'd4:  c = '{OP_SUB, R_Y,   R_PA,  R_D,   1'b1};
            6'd5:  c = '{OP_MUL, R_G0,  R_D,   R_T0,  1'b1};
            6'd6:  c = '{OP_ADD, R_PA,  R_T0,  R_TH,  1'b1};
            6'd7:  c = '{OP_MUL, R_G1,  R_D,   R_T0,  1'b1};
            6'd8:  c = '{OP_ADD, R_PB,  R_T0,  R_BI,  1'b1};
            6'd9:  c = '{OP_MUL, R_G0,  R_P00, R_T0,  1'b1};
            6'd10: c = '{OP_SUB, R_P00, R_T0,  R_C00, 1'b1};
            6'd11: c = '{OP_MUL, R_G0,  R_P01, R_T0,  1'b1};
            6'd12: c = '{OP_SUB, R_P01, R_T0,  R_C01, 1'b1};
            6'd13: c = '{OP_MUL, R_G1,  R_P00, R_T0,  1'b1};
            6'd14: c = '{OP_SUB, R_P10, R_T0,  R_C10, 1'b1};
            6'd15: c = '{OP_MUL, R_G1,  R_P01, R_T0,  1'b1};
            6'd16: c = '{OP_SUB, R_P11, R_T0,  R_C11, 1'b1};
            6'd17: c = '{OP_MUL, R_DT,  R_C10, R_T0,  1'b1};
            6'd18: c = '{OP_SUB, R_C00, R_T0,  R_A00, 1'b1};
            6'd19: c = '{OP_MUL, R_DT,  R_C11, R_T0,  1'b1};
            6'd20: c = '{OP_SUB, R_C01, R_T0,  R_A01, 1'b1};
            6'd21: c = '{OP_MUL, R_DT,  R_A01, R_T0,  1'b1};
            6'd22: c = '{OP_SUB, R_A00, R_T0,  R_T1,  1'b1};
            6'd23: c = '{OP_MUL, R_DT,  R_DT,  R_DD,  1'b1};
            6'd24: c = '{OP_MUL, R_DD,  R_Q,   R_T0,  1'b1};
            6'd25: c = '{OP_ADD, R_T1,  R_T0,  R_P00, 1'b1};
            6'd26: c = '{OP_ADD, R_A01, R_ZERO, R_P01, 1'b1};
            6'd27: c = '{OP_MUL, R_DT,  R_C11, R_T0,  1'b1};
            6'd28: c = '{OP_SUB, R_C10, R_T0,  R_P10, 1'b1};
            6'd29: c = '{OP_ADD, R_C11, R_ZERO, R_P11, 1'b1};
            6'd30: c = '{OP_MUL, R_DT,  R_BI,  R_T0,  1'b1};
            6'd31: c = '{OP_SUB, R_TH,  R_T0,  R_T1,  1'b1};
            6'd32: c = '{OP_MUL, R_DT,  R_U,   R_T0,  1'b1};
            6'd33: c = '{OP_ADD, R_T1,  R_T0,  R_PA,  1'b1};
            6'd34: c = '{OP_ADD, R_BI,  R_ZERO, R_PB, 1'b1};
            6'd35: c = '{OP_FINISH, R_TH, R_BI, R_ZERO, 1'b1};
            default: c = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO, 1'b0};
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

/* hdl/tkf_datapath.sv */
// Datapath of the tilt Kalman filter: register file, saturating ALU, multiplier, divider.
`default_nettype none
module tkf_datapath #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire  logic                              i_clk,
    input  wire  logic                              i_rst_n,
    input  wire  tkf_pkg::t_cmd                     i_cmd,
    output       tkf_pkg::t_status                  o_status,
    input  wire  logic                              i_cfg_en,
    input  wire  logic [tkf_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire  logic [tkf_pkg::CFG_WIDTH-1:0]     i_cfg_data,
    input  wire  logic [tkf_pkg::IN_WIDTH-1:0]      i_y,
    input  wire  logic [tkf_pkg::IN_WIDTH-1:0]      i_u,
    output       logic [tkf_pkg::OUT_WIDTH-1:0]     o_angle,
    output       logic [tkf_pkg::OUT_WIDTH-1:0]     o_bias,
    output       logic                              o_ovf
);
    import tkf_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int NREG = 27;
    localparam int CW = (DW > 8) ? $clog2(PW + FRAC_BITS + 1) : 4;
    localparam logic signed [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MAG_HI = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MAG_LO = {1'b1, {(DW-1){1'b0}}};
    localparam int QW = DW + FRAC_BITS;
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    // Configuration registers.
    logic [DT_WIDTH-1:0]  r_dt;
    logic [CFG_WIDTH-1:0] r_w, r_q;
    logic [IN_WIDTH-1:0]  r_ib;
    logic signed [DW-1:0] r_rf [NREG];
    logic r_ovf, r_busy;
    t_op  r_op;
    t_reg r_dst;
    logic r_neg;
    logic [DW-1:0] r_ma, r_mb;
    logic [PW-1:0] r_prod;
    logic [1:0] r_mph;
    logic [QW-1:0] r_num, r_quo;
    logic [DW:0]   r_rem;
    logic [CW-1:0] r_cnt;

    // Widened add and subtract helper; the caller saturates the result.
    function automatic logic signed [DW:0] wsum(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b,
                                                 input logic sub);
        logic signed [DW:0] r;
        if (sub) r = {a[DW-1], a} - {b[DW-1], b};
        else     r = {a[DW-1], a} + {b[DW-1], b};
        return r;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    // Clamp an unsigned configuration value into the data width.
    function automatic logic signed [DW-1:0] clampu(input logic [CFG_WIDTH-1:0] v,
                                                     output logic o);
        logic signed [DW-1:0] r;
        o = 1'b0;
        if (CFG_WIDTH >= DW && (v >> (DW - 1)) != '0) begin
            o = 1'b1;
            r = HI;
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] clamps(input logic [IN_WIDTH-1:0] v,
                                                     output logic o);
        logic signed [IN_WIDTH-1:0] s;
        logic signed [63:0] e;
        logic signed [DW-1:0] r;
        s = v;
        e = 64'(s);
        o = 1'b0;
        if (e > 64'(HI)) begin
            o = 1'b1;
            r = HI;
        end else if (e < 64'(LO)) begin
            o = 1'b1;
            r = LO;
        end else begin
            r = DW'(e);
        end
        return r;
    endfunction

    logic signed [DW-1:0] a_val, b_val;
    logic signed [DW:0]   sum;
    logic signed [DW-1:0] sum_sat;
    logic sum_ovf;
    logic [PW:0] rnd;
    logic [PW-FRAC_BITS:0] shf;
    logic signed [DW-1:0] mul_res, div_res;
    logic mul_ovf, div_ovf;
    logic [DW:0] trial;
    logic signed [DW-1:0] ld_y, ld_u, ld_dt, ld_w, ld_q, ld_b;
    logic o_y, o_u, o_dt, o_w, o_q, o_b;
    logic signed [63:0] ang64, bia64;

    assign a_val = r_rf[i_cmd.src_a];
    assign b_val = r_rf[i_cmd.src_b];

    // Adder with saturation.
    always_comb begin
        sum = wsum(a_val, b_val, i_cmd.op == OP_SUB);
        sum_ovf = sum[DW] != sum[DW-1];
        sum_sat = sum_ovf ? (sum[DW] ? LO : HI) : sum[DW-1:0];
    end

    // Product rounding and saturation.
    always_comb begin
        rnd = {1'b0, r_prod} + ((PW+1)'(1) << (FRAC_BITS - 1));
        shf = rnd[PW:FRAC_BITS];
        mul_ovf = 1'b0;
        mul_res = '0;
        if (r_neg) begin
            if (shf > (PW-FRAC_BITS+1)'(MAG_LO)) begin
                mul_ovf = 1'b1;
                mul_res = LO;
            end else begin
                mul_res = DW'(~shf + 1'b1);
            end
        end else if (shf > (PW-FRAC_BITS+1)'(MAG_HI)) begin
            mul_ovf = 1'b1;
            mul_res = HI;
        end else begin
            mul_res = DW'(shf);
        end
    end

    // Quotient saturation.
    always_comb begin
        div_ovf = 1'b0;
        div_res = '0;
        if (r_neg) begin
            if (r_quo > QW'(MAG_LO)) begin
                div_ovf = 1'b1;
                div_res = LO;
            end else begin
                div_res = DW'(~r_quo + 1'b1);
            end
        end else if (r_quo > QW'(MAG_HI)) begin
            div_ovf = 1'b1;
            div_res = HI;
        end else begin
            div_res = DW'(r_quo);
        end
        trial = {r_rem[DW-1:0], r_num[QW-1]} - {1'b0, r_mb};
    end

    always_comb begin
        ld_y  = clamps(i_y, o_y);
        ld_u  = clamps(i_u, o_u);
        ld_b  = clamps(r_ib, o_b);
        ld_dt = clampu(CFG_WIDTH'(r_dt), o_dt);
        ld_w  = clampu(r_w, o_w);
        ld_q  = clampu(r_q, o_q);
        ang64 = 64'(r_rf[R_TH]);
        bia64 = 64'(r_rf[R_BI]);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_WIDTH'(655);
            r_w  <= CFG_WIDTH'(65536);
            r_q  <= CFG_WIDTH'(65536);
            r_ib <= '0;
        end else if (i_cfg_en) begin
            case (i_cfg_idx)
                REG_DT:   r_dt <= i_cfg_data[DT_WIDTH-1:0];
                REG_W:    r_w  <= i_cfg_data;
                REG_Q:    r_q  <= i_cfg_data;
                REG_BIAS: r_ib <= i_cfg_data[IN_WIDTH-1:0];
                default:  r_ib <= r_ib;
            endcase
        end
    end

    // Operation execution; multiply and divide hold the busy flag until their result is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovf  <= 1'b0;
            r_op   <= OP_NOP;
            for (int k = 0; k < NREG; k++) r_rf[k] <= '0;
            r_rf[R_P00] <= ONE;
            r_rf[R_P11] <= ONE;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                // Product first, then round and write.
                if (r_mph == 2'd0) begin
                    r_prod <= PW'(r_ma) * PW'(r_mb);
                    r_mph  <= 2'd1;
                end else begin
                    r_rf[r_dst] <= mul_res;
                    r_ovf  <= r_ovf | mul_ovf;
                    r_busy <= 1'b0;
                end
            end else begin
                // One quotient bit per cycle.
                if (r_cnt != '0) begin
                    if (!trial[DW]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DW-1:0], r_num[QW-1]};
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                    r_num <= {r_num[QW-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_rf[r_dst] <= div_res;
                    r_ovf  <= r_ovf | div_ovf;
                    r_busy <= 1'b0;
                end
            end
        end else if (i_cmd.start) begin
            case (i_cmd.op)
                OP_ADD, OP_SUB: begin
                    r_rf[i_cmd.dst] <= sum_sat;
                    r_ovf <= r_ovf | sum_ovf;
                end
                OP_MUL: begin
                    r_op  <= OP_MUL;
                    r_dst <= i_cmd.dst;
                    r_neg <= a_val[DW-1] ^ b_val[DW-1];
                    r_ma  <= mag(a_val);
                    r_mb  <= mag(b_val);
                    r_mph <= 2'd0;
                    r_busy <= 1'b1;
                end
                OP_DIV: begin
                    if (b_val == '0) begin
                        r_rf[i_cmd.dst] <= '0;
                        r_ovf <= 1'b1;
                    end else begin
                        r_op  <= OP_DIV;
                        r_dst <= i_cmd.dst;
                        r_neg <= a_val[DW-1] ^ b_val[DW-1];
                        r_num <= {mag(a_val), {FRAC_BITS{1'b0}}};
                        r_mb  <= mag(b_val);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= CW'(QW);
                        r_busy <= 1'b1;
                    end
                end
                OP_LOAD: begin
                    r_rf[R_Y]  <= ld_y;
                    r_rf[R_U]  <= ld_u;
                    r_rf[R_DT] <= ld_dt;
                    r_rf[R_W]  <= ld_w;
                    r_rf[R_Q]  <= ld_q;
                    r_ovf <= o_y | o_u | o_dt | o_w | o_q;
                end
                OP_RESTART: begin
                    r_rf[R_PA]  <= '0;
                    r_rf[R_PB]  <= ld_b;
                    r_rf[R_P00] <= ONE;
                    r_rf[R_P01] <= '0;
                    r_rf[R_P10] <= '0;
                    r_rf[R_P11] <= ld_q;
                    r_rf[R_TH]  <= '0;
                    r_rf[R_BI]  <= ld_b;
                    r_ovf <= o_b | o_q;
                end
                OP_FINISH: begin
                    if (ang64 > 64'sd2147483647 || ang64 < -64'sd2147483648 ||
                        bia64 > 64'sd2147483647 || bia64 < -64'sd2147483648)
                        r_ovf <= 1'b1;
                end
                default: r_ovf <= r_ovf;
            endcase
        end
    end

    // Output clamp to 32 bits.
    always_comb begin
        o_angle = ang64 > 64'sd2147483647 ? 32'h7fffffff :
                  ang64 < -64'sd2147483648 ? 32'h80000000 : ang64[31:0];
        o_bias  = bia64 > 64'sd2147483647 ? 32'h7fffffff :
                  bia64 < -64'sd2147483648 ? 32'h80000000 : bia64[31:0];
        o_ovf   = r_ovf;
        o_status.busy = r_busy;
    end
endmodule
`default_nettype wire

/* hdl/tkf_controller.sv */
// Sequencer of the tilt Kalman filter: steps the microprogram and runs the handshakes.
`default_nettype none
module tkf_controller (
    input  wire  logic             i_clk,
    input  wire  logic             i_rst_n,
    input  wire  logic             i_valid,
    output       logic             o_ready,
    input  wire  logic             i_command,
    output       logic             o_valid,
    input  wire  logic             i_ready,
    output       tkf_pkg::t_cmd    o_cmd,
    input  wire  tkf_pkg::t_status i_status
);
    import tkf_pkg::*;

    t_state r_state, n_state;
    logic [PC_WIDTH-1:0] r_pc, n_pc;
    t_cmd   cur;

    assign cur = prog(r_pc);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Next state. The load step runs at acceptance, so the program resumes at step one.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_pc    = PC_WIDTH'(1);
                    n_state = (i_command == CMD_RESTART) ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_status.busy) begin
                    if (cur.op == OP_FINISH) begin
                        n_state = ST_OUT;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs. The input fields are captured in the cycle the word is accepted.
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd   = '{OP_NOP, R_ZERO, R_ZERO, R_ZERO, 1'b0};
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_command == CMD_RESTART)
                        o_cmd = '{OP_RESTART, R_ZERO, R_ZERO, R_ZERO, 1'b1};
                    else
                        o_cmd = prog(PC_WIDTH'(0));
                end
            end
            ST_ISSUE: o_cmd = cur;
            ST_OUT:   o_valid = 1'b1;
            default:  o_valid = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/tilt_kalman_filter_unit.sv */
// Top level of the tilt Kalman filter unit.
// Usage:
//   Input channel i_valid/o_ready carries one word: a command (restart or
//   update), an accelerometer angle and a gyro rate, signed Q9.16 degrees.
//   Output channel o_valid/i_ready carries the corrected angle and bias and
//   an overflow flag, one word per input word.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Operation:
//   A restart word gives its result in the cycle after acceptance.
//   An update word runs a 36-step microprogram on one shared saturating ALU,
//   a multiplier that forms the product and then rounds it, and a bit-serial
//   divider. One word at a time.
// Reset:
//   Synchronous active-low reset restores default registers, zero angle and
//   bias prediction and an identity covariance.
// Stall:
//   A result holds on the output until taken; no new word is accepted
//   before then.
`default_nettype none
`include "assert_macros.svh"
module tilt_kalman_filter_unit #(
    parameter int FRAC_BITS  = tkf_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = tkf_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic                              i_command,
    input  wire logic [tkf_pkg::IN_WIDTH-1:0]      i_accel_angle,
    input  wire logic [tkf_pkg::IN_WIDTH-1:0]      i_gyro_rate,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic [tkf_pkg::OUT_WIDTH-1:0]     o_est_angle,
    output      logic [tkf_pkg::OUT_WIDTH-1:0]     o_est_bias,
    output      logic                              o_overflow,
    input  wire logic                              i_cfg_we,
    input  wire logic [tkf_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [tkf_pkg::CFG_WIDTH-1:0]     i_cfg_data
);
    import tkf_pkg::*;

    t_cmd    cmd;
    t_status status;

    tkf_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    tkf_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_en   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_y        (i_accel_angle),
        .i_u        (i_gyro_rate),
        .o_angle    (o_est_angle),
        .o_bias     (o_est_bias),
        .o_ovf      (o_overflow)
    );

    `ASSERT_ALWAYS(a_no_both, i_clk, i_rst_n, !(o_ready && o_valid))
    `ASSERT_NEXT(a_take_done, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
    `ASSERT_NEXT(a_busy_blocks, i_clk, i_rst_n, status.busy, !o_valid)
endmodule
`default_nettype wire

/* dv/tb_tilt_kalman_filter_unit.sv */
// Self-checking testbench of the tilt Kalman filter unit with its own filter predictor.
`default_nettype none
module tb_tilt_kalman_filter_unit;
    import tkf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd65536;

    typedef struct {
        logic                cmd;
        logic [IN_WIDTH-1:0] angle;
        logic [IN_WIDTH-1:0] rate;
    } t_sample;

    typedef struct {
        logic [OUT_WIDTH-1:0] angle;
        logic [OUT_WIDTH-1:0] bias;
        logic                 ovf;
    } t_estimate;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_command = CMD_RESTART;
    logic [IN_WIDTH-1:0]      i_accel_angle = '0;
    logic [IN_WIDTH-1:0]      i_gyro_rate = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [OUT_WIDTH-1:0]     o_est_angle;
    logic [OUT_WIDTH-1:0]     o_est_bias;
    logic                     o_overflow;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx = REG_DT;
    logic [CFG_WIDTH-1:0]     i_cfg_data = '0;

    tilt_kalman_filter_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_sample   sample_q[$];
    t_estimate estimate_q[$];
    int        errors = 0;
    int        words_in = 0;
    int        words_out = 0;
    int        words_queued = 0;
    logic      quiet = 1'b0;
    logic      long_hold = 1'b0;

    // Predictor copy of registers and filter state.
    longint dt_reg = 655, w_reg = 65536, q_reg = 65536, bias0_reg = 0;
    longint pa = 0, pb = 0;
    longint cov[4] = '{ONE_Q, 0, 0, ONE_Q};
    bit     sat_hit;

    function automatic longint clip(input longint v);
        if (v > SAT_HI) begin
            sat_hit = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            sat_hit = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clip(a + b);
    endfunction

    function automatic longint qsub(input longint a, input longint b);
        return clip(a - b);
    endfunction

    // Product with the magnitude rounded half away from zero.
    function automatic longint qmul(input longint a, input longint b);
        longint p, m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + 64'sd32768) >>> 16;
        return clip((p < 0) ? -m : m);
    endfunction

    // Quotient truncated toward zero; a zero divisor gives zero.
    function automatic longint qdiv(input longint p, input longint s);
        longint mp, d, r;
        if (s == 0) begin
            sat_hit = 1'b1;
            return 0;
        end
        mp = (p < 0) ? -p : p;
        d  = (s < 0) ? -s : s;
        r  = (mp <<< 16) / d;
        return clip(((p < 0) != (s < 0)) ? -r : r);
    endfunction

    function automatic longint sx25(input logic [IN_WIDTH-1:0] v);
        return longint'(signed'(v));
    endfunction

    // One filter step of the predictor.
    function automatic t_estimate filter_step(input t_sample smp);
        t_estimate e;
        longint q, th, bi, y, u, dt, w, s, g0, g1, d;
        longint c00, c01, c10, c11, a00, a01;
        sat_hit = 1'b0;
        q = clip(q_reg);
        if (smp.cmd == CMD_RESTART) begin
            pa = 0;
            pb = clip(bias0_reg);
            cov[0] = ONE_Q;
            cov[1] = 0;
            cov[2] = 0;
            cov[3] = q;
            th = 0;
            bi = pb;
        end else begin
            y  = clip(sx25(smp.angle));
            u  = clip(sx25(smp.rate));
            dt = clip(dt_reg);
            w  = clip(w_reg);
            s  = qadd(cov[0], w);
            g0 = qdiv(cov[0], s);
            g1 = qdiv(cov[2], s);
            d  = qsub(y, pa);
            th = qadd(pa, qmul(g0, d));
            bi = qadd(pb, qmul(g1, d));
            c00 = qsub(cov[0], qmul(g0, cov[0]));
            c01 = qsub(cov[1], qmul(g0, cov[1]));
            c10 = qsub(cov[2], qmul(g1, cov[0]));
            c11 = qsub(cov[3], qmul(g1, cov[1]));
            a00 = qsub(c00, qmul(dt, c10));
            a01 = qsub(c01, qmul(dt, c11));
            cov[0] = qadd(qsub(a00, qmul(dt, a01)), qmul(qmul(dt, dt), q));
            cov[1] = a01;
            cov[2] = qsub(c10, qmul(dt, c11));
            cov[3] = c11;
            pa = qadd(qsub(th, qmul(dt, bi)), qmul(dt, u));
            pb = bi;
        end
        e.angle = th[31:0];
        e.bias  = bi[31:0];
        e.ovf   = sat_hit;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("word %0d: %s got %h expected %h", words_out, what, got, want);
        errors++;
    endtask

    // Driver: offers queued words, with random idle bursts.
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic    nv;
        t_sample s;
        nv = i_valid;
        if (i_valid && o_ready) begin
            s.cmd = i_command;
            s.angle = i_accel_angle;
            s.rate = i_gyro_rate;
            estimate_q.push_back(filter_step(s));
            words_in++;
            nv = 1'b0;
        end
        if (i_rst_n && !nv) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (sample_q.size() > 0) begin
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 2);
                end else begin
                    s = sample_q.pop_front();
                    i_command <= s.cmd;
                    i_accel_angle <= s.angle;
                    i_gyro_rate <= s.rate;
                    nv = 1'b1;
                end
            end
        end
        i_valid <= nv;
    end

    // Monitor: checks each taken word and stalls the output side.
    int recv_gap = 0;
    int hold_count = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_estimate e;
        logic      nr;
        if (o_valid && i_ready) begin
            if (estimate_q.size() == 0) begin
                report_mismatch("unexpected word angle", o_est_angle, '0);
            end else begin
                e = estimate_q.pop_front();
                if (o_est_angle !== e.angle) report_mismatch("angle", o_est_angle, e.angle);
                if (o_est_bias !== e.bias) report_mismatch("bias", o_est_bias, e.bias);
                if (o_overflow !== e.ovf)
                    report_mismatch("overflow", 32'(o_overflow), 32'(e.ovf));
            end
            words_out++;
        end
        nr = 1'b1;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (long_hold && !hold_done) begin
            hold_count++;
            nr = 1'b0;
            if (hold_count >= 2000) hold_done = 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 2);
            nr = 1'b0;
        end
        i_ready <= nr;
    end

    task automatic add_word(input logic cmd, input logic [IN_WIDTH-1:0] a,
                            input logic [IN_WIDTH-1:0] r);
        t_sample s;
        s.cmd = cmd;
        s.angle = a;
        s.rate = r;
        sample_q.push_back(s);
        words_queued++;
    endtask

    // Waits until every queued word has been taken and its result checked.
    task automatic drain();
        while (words_out < words_queued) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_DT:   dt_reg = longint'(val[16:0]);
            REG_W:    w_reg = longint'(val[30:0]);
            REG_Q:    q_reg = longint'(val[30:0]);
            REG_BIAS: bias0_reg = sx25(val[24:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [30:0] dt, input logic [30:0] w,
                            input logic [30:0] q, input logic [30:0] b);
        write_reg(REG_DT, dt);
        write_reg(REG_W, w);
        write_reg(REG_Q, q);
        write_reg(REG_BIAS, b);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random values: mostly in range, sometimes any 25-bit pattern.
    function automatic logic [IN_WIDTH-1:0] rnd_field(input int lim);
        if ($urandom_range(0, 7) == 0) return IN_WIDTH'($urandom);
        if ($urandom_range(0, 9) == 0) return IN_WIDTH'($urandom_range(0, 1) ? lim : -lim);
        return IN_WIDTH'($urandom_range(0, 2 * lim) - lim);
    endfunction

    task automatic random_phase(input int n);
        add_word(CMD_RESTART, IN_WIDTH'($urandom), IN_WIDTH'($urandom));
        repeat (n - 1) begin
            if ($urandom_range(0, 19) == 0)
                add_word(CMD_RESTART, IN_WIDTH'($urandom), IN_WIDTH'($urandom));
            else
                add_word(CMD_UPDATE, rnd_field(11796480), rnd_field(16384000));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, field extremes, restart mid-run.
        add_word(CMD_UPDATE, 25'd11796480, 25'd16384000);
        add_word(CMD_UPDATE, -25'sd11796480, -25'sd16384000);
        add_word(CMD_UPDATE, '0, '0);
        add_word(CMD_UPDATE, 25'h0FFFFFF, 25'h1000000);
        add_word(CMD_RESTART, '1, '1);
        add_word(CMD_UPDATE, 25'h1000000, 25'h0FFFFFF);
        drain();
        // Largest dt and variances and a large bias drive saturation.
        set_regs(31'h1FFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd16384000);
        add_word(CMD_RESTART, '0, '0);
        repeat (4) add_word(CMD_UPDATE, 25'd11796480, 25'd16384000);
        add_word(CMD_UPDATE, -25'sd11796480, -25'sd16384000);
        drain();
        // Smallest dt and w with zero q; the group after it writes a zero dt.
        set_regs(31'd1, 31'd1, 31'd0, -31'sd16384000);
        add_word(CMD_RESTART, '0, '0);
        repeat (3) add_word(CMD_UPDATE, 25'd11796480, -25'sd16384000);
        drain();
        set_regs(31'h7FFE0000, 31'd0, 31'd65536, 31'd0);
        add_word(CMD_RESTART, '0, '0);
        repeat (3) add_word(CMD_UPDATE, 25'd1000, 25'd5000);
        drain();

        // Random phases with differing registers; the sender waits between them.
        set_regs(31'd655, 31'd65536, 31'd65536, 31'd0);
        random_phase(250);
        long_hold <= 1'b1;
        drain();
        repeat (2) begin
            set_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
            random_phase(250);
            drain();
        end
        set_regs(31'd6554, 31'd20000, 31'd300, 31'd70000);
        random_phase(250);
        drain();
        set_regs(31'd65536, 31'd65536000, 31'd6, -31'sd300000);
        random_phase(250);
        drain();
        set_regs(31'(100 + $urandom_range(0, 3000)), 31'($urandom_range(1, 1000000)),
                 31'($urandom_range(0, 100000)),
                 31'($urandom_range(0, 2000000) - 1000000));
        quiet <= 1'b1;
        random_phase(280);
        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d words sent, %0d results checked over nine register settings", words_in,
                 words_out);
        $display("covered restarts, saturation, zero dt and stalls on both channels");
        if (errors == 0 && estimate_q.size() == 0) begin
            $display("tilt_kalman_filter_unit: match");
        end else begin
            $display("tilt_kalman_filter_unit: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #30ms;
        $display("timeout");
        $display("tilt_kalman_filter_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
